@@ design/atsd_pkg.sv @@
`timescale 1ns / 1ps
// atsd_pkg: shared types, constants and mode preset lookup for the step detector
// no dependencies; used by every other file of the block but atsd_sample_if and atsd_delta

package atsd_pkg;

  localparam int THR_BITS     = 8;
  localparam int MODE_BITS    = 2;
  localparam int RESULT_BITS  = 32;
  localparam int ADAPT_MARGIN = 200;
  localparam int ADAPT_STEP   = 2;

  localparam logic [MODE_BITS-1:0] MODE_REGULAR        = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_NOT_SENSITIVE  = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_VERY_SENSITIVE = 2'd3;

  typedef struct packed {
    logic [THR_BITS-1:0] x_limit;
    logic [THR_BITS-1:0] start;
    logic [THR_BITS-1:0] lo;
    logic [THR_BITS-1:0] hi;
  } band_t;

  // mode zero falls back to the regular presets
  function automatic band_t band_of(logic [MODE_BITS-1:0] mode);
    band_t b;
    unique case (mode)
      MODE_NOT_SENSITIVE: begin
        b.x_limit = 8'd45;
        b.start   = 8'd235;
        b.lo      = 8'd225;
        b.hi      = 8'd245;
      end
      MODE_VERY_SENSITIVE: begin
        b.x_limit = 8'd25;
        b.start   = 8'd110;
        b.lo      = 8'd100;
        b.hi      = 8'd120;
      end
      default: begin
        b.x_limit = 8'd35;
        b.start   = 8'd185;
        b.lo      = 8'd175;
        b.hi      = 8'd195;
      end
    endcase
    return b;
  endfunction

endpackage

@@ design/atsd_sample_if.sv @@
`timescale 1ns / 1ps
// atsd_sample_if: valid/ready channel carrying one accelerometer sample beat
// no dependencies

interface atsd_sample_if #(
  parameter int SAMPLE_BITS = 13
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;
  logic                          vibrating;

  modport source (output valid, accel_x, accel_y, accel_z, vibrating, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, vibrating, output ready);
endinterface

@@ design/atsd_result_if.sv @@
`timescale 1ns / 1ps
// atsd_result_if: valid/ready channel carrying one step result beat
// depends on atsd_pkg for the result width

interface atsd_result_if;
  logic                              valid;
  logic                              ready;
  logic                              step_detected;
  logic [atsd_pkg::RESULT_BITS-1:0]  step_total;

  modport source (output valid, step_detected, step_total, input ready);
  modport sink   (input valid, step_detected, step_total, output ready);
endinterface

@@ design/atsd_cfg_if.sv @@
`timescale 1ns / 1ps
// atsd_cfg_if: valid/ready write channel for the sensitivity mode register
// depends on atsd_pkg for the mode width

interface atsd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [atsd_pkg::MODE_BITS-1:0]  sensitivity_mode;

  modport source (output valid, sensitivity_mode, input ready);
  modport sink   (input valid, sensitivity_mode, output ready);
endinterface

@@ design/atsd_delta.sv @@
`timescale 1ns / 1ps
// atsd_delta: absolute change in magnitude between two signed samples
// no package dependencies

module atsd_delta #(
  parameter int SAMPLE_BITS = 13
) (
  input  logic signed [SAMPLE_BITS-1:0] cur,
  input  logic signed [SAMPLE_BITS-1:0] prev,
  output logic        [SAMPLE_BITS-1:0] change
);

  logic signed [SAMPLE_BITS:0] cur_e;
  logic signed [SAMPLE_BITS:0] prev_e;
  logic signed [SAMPLE_BITS:0] cur_abs;
  logic signed [SAMPLE_BITS:0] prev_abs;
  logic signed [SAMPLE_BITS:0] diff;
  logic signed [SAMPLE_BITS:0] diff_abs;

  // magnitudes reach 2^(SAMPLE_BITS-1), so one extra bit keeps the negate exact
  always_comb begin
    cur_e    = {cur[SAMPLE_BITS-1], cur};
    prev_e   = {prev[SAMPLE_BITS-1], prev};
    cur_abs  = cur_e[SAMPLE_BITS] ? -cur_e : cur_e;
    prev_abs = prev_e[SAMPLE_BITS] ? -prev_e : prev_e;
    diff     = cur_abs - prev_abs;
    diff_abs = diff[SAMPLE_BITS] ? -diff : diff;
    change   = diff_abs[SAMPLE_BITS-1:0];
  end

endmodule

@@ design/atsd_adapt.sv @@
`timescale 1ns / 1ps
// atsd_adapt: threshold test and band-limited raise for one adaptive axis
// depends on atsd_pkg for band_t and the adapt constants

module atsd_adapt #(
  parameter int SAMPLE_BITS = 13
) (
  input  logic [SAMPLE_BITS-1:0]         change,
  input  logic [atsd_pkg::THR_BITS-1:0]  thr,
  input  atsd_pkg::band_t                band,
  output logic                           qualify,
  output logic [atsd_pkg::THR_BITS-1:0]  thr_next
);

  localparam int CMPW = SAMPLE_BITS + 2;

  logic [CMPW-1:0]                chg_w;
  logic [CMPW-1:0]                thr_w;
  logic                           over;
  logic [atsd_pkg::THR_BITS-1:0]  thr_clamp;

  always_comb begin
    chg_w   = CMPW'(change);
    thr_w   = CMPW'(thr);
    qualify = chg_w >= thr_w;
    over    = chg_w > (thr_w + CMPW'(atsd_pkg::ADAPT_MARGIN));
    priority if (thr > band.hi) begin
      thr_clamp = band.hi;
    end else if (thr < band.lo) begin
      thr_clamp = band.lo;
    end else begin
      thr_clamp = thr;
    end
    // over implies qualify
    if (over) begin
      thr_next = (thr_clamp < band.hi)
               ? thr_clamp + atsd_pkg::THR_BITS'(atsd_pkg::ADAPT_STEP)
               : thr_clamp;
    end else begin
      thr_next = thr;
    end
  end

endmodule

@@ design/adaptive_threshold_step_detector.sv @@
`timescale 1ns / 1ps
// Step detector: one accelerometer sample per cycle while results are taken; a sample beat
// is taken into an input register and, in the cycle it leaves it, is compared with the
// previous sample, the Y and Z thresholds adapt and the saturating step count updates, all
// in that cycle, with the result landing in an output register. Sustained rate is one
// sample per clock; each sample's update of thresholds and counter is done in time for
// the next. A stalled result holds the pipeline; one sample may wait in the input
// register meanwhile. Mode writes reload both adaptive thresholds to the mode's start
// value and keep the count and old samples.
// depends on atsd_pkg, atsd_sample_if, atsd_result_if, atsd_cfg_if, atsd_delta, atsd_adapt

module adaptive_threshold_step_detector #(
  parameter int SAMPLE_BITS = 13,
  parameter int COUNT_BITS  = 32
) (
  input  logic                clk,
  input  logic                rst,
  atsd_sample_if.sink         sample,
  atsd_result_if.source       result,
  atsd_cfg_if.sink            cfg
);

  localparam int CMPW = SAMPLE_BITS + 2;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam atsd_pkg::band_t RESET_BAND = atsd_pkg::band_of(atsd_pkg::MODE_REGULAR);

  // input register
  logic                          in_valid;
  logic signed [SAMPLE_BITS-1:0] in_x;
  logic signed [SAMPLE_BITS-1:0] in_y;
  logic signed [SAMPLE_BITS-1:0] in_z;
  logic                          in_vib;

  // block state
  logic [atsd_pkg::MODE_BITS-1:0] mode;
  logic signed [SAMPLE_BITS-1:0]  previous_x;
  logic signed [SAMPLE_BITS-1:0]  previous_y;
  logic signed [SAMPLE_BITS-1:0]  previous_z;
  logic [atsd_pkg::THR_BITS-1:0]  y_threshold;
  logic [atsd_pkg::THR_BITS-1:0]  z_threshold;
  logic [COUNT_BITS-1:0]          step_counter;

  logic                           fire;
  atsd_pkg::band_t                band;
  atsd_pkg::band_t                cfg_band;
  logic [SAMPLE_BITS-1:0]         change_x;
  logic [SAMPLE_BITS-1:0]         change_y;
  logic [SAMPLE_BITS-1:0]         change_z;
  logic                           qual_x;
  logic                           qual_y;
  logic                           qual_z;
  logic [atsd_pkg::THR_BITS-1:0]  y_threshold_next;
  logic [atsd_pkg::THR_BITS-1:0]  z_threshold_next;
  logic                           step;
  logic [COUNT_BITS-1:0]          step_counter_next;

  assign fire         = in_valid && (!result.valid || result.ready);
  assign sample.ready = !in_valid || fire;
  assign cfg.ready    = 1'b1;
  assign band         = atsd_pkg::band_of(mode);
  assign cfg_band     = atsd_pkg::band_of(cfg.sensitivity_mode);

  atsd_delta #(.SAMPLE_BITS(SAMPLE_BITS)) u_delta_x (
    .cur(in_x), .prev(previous_x), .change(change_x)
  );
  atsd_delta #(.SAMPLE_BITS(SAMPLE_BITS)) u_delta_y (
    .cur(in_y), .prev(previous_y), .change(change_y)
  );
  atsd_delta #(.SAMPLE_BITS(SAMPLE_BITS)) u_delta_z (
    .cur(in_z), .prev(previous_z), .change(change_z)
  );

  atsd_adapt #(.SAMPLE_BITS(SAMPLE_BITS)) u_adapt_y (
    .change(change_y), .thr(y_threshold), .band(band),
    .qualify(qual_y), .thr_next(y_threshold_next)
  );
  atsd_adapt #(.SAMPLE_BITS(SAMPLE_BITS)) u_adapt_z (
    .change(change_z), .thr(z_threshold), .band(band),
    .qualify(qual_z), .thr_next(z_threshold_next)
  );

  always_comb begin
    qual_x = CMPW'(change_x) >= CMPW'(band.x_limit);
    step   = qual_x && (qual_y || qual_z) && !in_vib;
    step_counter_next = (step && step_counter != COUNT_MAX) ? step_counter + 1'b1
                                                            : step_counter;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
    if (sample.valid && sample.ready) begin
      in_x   <= sample.accel_x;
      in_y   <= sample.accel_y;
      in_z   <= sample.accel_z;
      in_vib <= sample.vibrating;
    end
  end

  // state update, config writes take the mode and reload the thresholds
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= atsd_pkg::MODE_REGULAR;
      previous_x   <= '0;
      previous_y   <= '0;
      previous_z   <= '0;
      y_threshold  <= RESET_BAND.start;
      z_threshold  <= RESET_BAND.start;
      step_counter <= '0;
    end else begin
      if (fire) begin
        previous_x   <= in_x;
        previous_y   <= in_y;
        previous_z   <= in_z;
        step_counter <= step_counter_next;
      end
      priority if (cfg.valid) begin
        mode        <= cfg.sensitivity_mode;
        y_threshold <= cfg_band.start;
        z_threshold <= cfg_band.start;
      end else if (fire) begin
        y_threshold <= y_threshold_next;
        z_threshold <= z_threshold_next;
      end else begin
        y_threshold <= y_threshold;
        z_threshold <= z_threshold;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (fire) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
    if (fire) begin
      result.step_detected <= step;
      result.step_total    <= atsd_pkg::RESULT_BITS'(step_counter_next);
    end
  end

  // counter moves only when a sample is processed
  a_counter_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(step_counter))
    else $error("step counter changed without a processed sample");

  // a counted step advances the counter by one unless it is full
  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    fire && step |=> (step_counter == $past(step_counter) + 1'b1) ||
                     ($past(step_counter) == COUNT_MAX))
    else $error("counted step did not advance the counter");

  // a waiting sample is never dropped
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !fire |=> in_valid && $stable(in_x) && $stable(in_y) && $stable(in_z))
    else $error("pending sample lost from input register");

  // adaptive thresholds stay inside the band of the current mode
  a_band: assert property (@(posedge clk) disable iff (rst)
    (y_threshold >= band.lo) && (y_threshold <= band.hi) &&
    (z_threshold >= band.lo) && (z_threshold <= band.hi))
    else $error("adaptive threshold left its band");

endmodule
